// ===== hw/rtl/rfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_pkg: shared types and constants of the RPC frame deframer
// Field codes, error kinds, register indexes, frame layout constants and the
// structs that travel between the deframer's modules.
// ----------------------------------------------------------------------------
package rfd_pkg;

	// Tag attached to every byte; also used as the parser phase.
	typedef enum logic [3:0] {
		FC_HUNT     = 4'd0,
		FC_START    = 4'd1,
		FC_TOTAL    = 4'd2,
		FC_IDLEN    = 4'd3,
		FC_ID       = 4'd4,
		FC_NAMELEN  = 4'd5,
		FC_NAME     = 4'd6,
		FC_ERR      = 4'd7,
		FC_INFOLEN  = 4'd8,
		FC_INFO     = 4'd9,
		FC_PAYLOAD  = 4'd10,
		FC_CHECKSUM = 4'd11,
		FC_END      = 4'd12
	} field_code_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_END_BYTE = 2'd1,
		ERR_OVERRUN  = 2'd2,
		ERR_BAD_LEN  = 2'd3
	} error_kind_t;

	typedef enum logic [1:0] {
		REG_START_BYTE    = 2'd0,
		REG_END_BYTE      = 2'd1,
		REG_MAX_FRAME_LEN = 2'd2,
		REG_UNUSED        = 2'd3
	} cfg_index_t;

	localparam logic [7:0]  START_BYTE_RST    = 8'd2;
	localparam logic [7:0]  END_BYTE_RST      = 8'd3;
	localparam logic [15:0] MAX_FRAME_LEN_RST = 16'hFFFF;

	// Smallest legal frame: start, total, id len, name len, err code,
	// info len, checksum and end byte.
	localparam logic [31:0] MIN_FRAME_LEN   = 32'd26;
	// Mandatory bytes that must still fit after a variable field.
	localparam logic [33:0] TAIL_AFTER_ID   = 34'd17;
	localparam logic [33:0] TAIL_AFTER_NAME = 34'd13;
	localparam logic [33:0] TAIL_AFTER_INFO = 34'd5;
	localparam logic [31:0] LEN_FIELD_BYTES = 32'd4;

	typedef struct packed {
		logic [7:0]  start_byte;
		logic [7:0]  end_byte;
		logic [15:0] max_frame_len;
	} rfd_cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		field_code_t field_code;
		logic [15:0] field_offset;
		logic        frame_done;
		logic        frame_ok;
		error_kind_t error_kind;
	} rfd_result_t;

endpackage : rfd_pkg
`default_nettype wire

// ===== hw/rtl/rfd_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_cfg_regs: configuration registers of the deframer
// Holds start byte, end byte and maximum frame length; a write completes in
// the cycle it is offered.
// ----------------------------------------------------------------------------
module rfd_cfg_regs
	import rfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_data,
	output rfd_cfg_t         cfg
);

	cfg_index_t idx;
	rfd_cfg_t   cfg_q;

	assign idx       = cfg_index_t'(cfg_addr);
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= START_BYTE_RST;
			cfg_q.end_byte      <= END_BYTE_RST;
			cfg_q.max_frame_len <= MAX_FRAME_LEN_RST;
		end else if (cfg_valid) begin
			unique case (idx)
				REG_START_BYTE:    cfg_q.start_byte    <= cfg_data[7:0];
				REG_END_BYTE:      cfg_q.end_byte      <= cfg_data[7:0];
				REG_MAX_FRAME_LEN: cfg_q.max_frame_len <= cfg_data;
				REG_UNUSED:        ;
			endcase
		end
	end

endmodule : rfd_cfg_regs
`default_nettype wire

// ===== hw/rtl/rfd_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_parser: frame walking state and per-byte classification
// Holds the parse state, classifies the byte at its input in the same cycle
// and commits the next state when enabled.
// ----------------------------------------------------------------------------
module rfd_parser
	import rfd_pkg::*;
#(
	parameter int POSITION_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [7:0] rx_byte,
	input  rfd_cfg_t        cfg,
	output rfd_result_t     res
);

	localparam logic [32:0] PosMask = (33'd1 << POSITION_BITS) - 33'd1;

	field_code_t              phase_q, phase_d;
	logic [POSITION_BITS-1:0] fpos_q, fpos_d;    // frame position
	logic [POSITION_BITS-1:0] lpos_q, lpos_d;    // position inside field
	logic [31:0]              shift_q, shift_d;
	logic [15:0]              total_q, total_d;
	logic [31:0]              rem_q, rem_d;

	logic        hunting;
	logic [31:0] len;
	logic [31:0] rem_dec;
	logic [31:0] lpos_ext;
	logic [32:0] lim;
	logic [33:0] fit_base;
	logic        over_id, over_name, over_info;
	logic [32:0] left;
	logic        left_small;
	logic [31:0] pay;

	assign hunting = (phase_q < FC_TOTAL) || (phase_q > FC_END);
	assign len     = {shift_q[23:0], rx_byte};
	assign rem_dec = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
	assign lpos_ext = 32'(lpos_q);

	// Total length must not exceed what the position counters can hold.
	assign lim = ({17'd0, cfg.max_frame_len} < PosMask) ? {17'd0, cfg.max_frame_len}
	                                                   : PosMask;

	// Positions below use the frame position after this byte.
	assign fit_base  = 34'(fpos_q + 1'b1) + {2'b00, len};
	assign over_id   = fit_base + TAIL_AFTER_ID   > {18'd0, total_q};
	assign over_name = fit_base + TAIL_AFTER_NAME > {18'd0, total_q};
	assign over_info = fit_base + TAIL_AFTER_INFO > {18'd0, total_q};

	// Payload size: bytes left minus info-tail, wrapping like a wide subtract.
	assign left       = {17'd0, total_q} - 33'(fpos_q + 1'b1);
	assign left_small = !left[32] && (left[31:0] < 32'(TAIL_AFTER_INFO));
	assign pay        = left_small ? 32'd0 : left[31:0] - 32'(TAIL_AFTER_INFO);

	always_comb begin
		phase_d = phase_q;
		fpos_d  = fpos_q;
		lpos_d  = lpos_q;
		shift_d = shift_q;
		total_d = total_q;
		rem_d   = rem_q;

		res.data_byte    = rx_byte;
		res.field_code   = FC_HUNT;
		res.field_offset = 16'd0;
		res.frame_done   = 1'b0;
		res.frame_ok     = 1'b0;
		res.error_kind   = ERR_NONE;

		if (hunting) begin
			phase_d = FC_HUNT;
			if (rx_byte == cfg.start_byte) begin
				res.field_code = FC_START;
				fpos_d  = POSITION_BITS'(1);
				shift_d = 32'd0;
				total_d = 16'd0;
				phase_d = FC_TOTAL;
				lpos_d  = '0;
				rem_d   = LEN_FIELD_BYTES;
			end
		end else begin
			res.field_code   = phase_q;
			res.field_offset = lpos_ext[15:0];
			fpos_d  = fpos_q + 1'b1;
			lpos_d  = lpos_q + 1'b1;
			rem_d   = rem_dec;
			shift_d = len;

			if (phase_q == FC_END) begin
				res.frame_done = 1'b1;
				res.frame_ok   = (rx_byte == cfg.end_byte);
				res.error_kind = (rx_byte == cfg.end_byte) ? ERR_NONE : ERR_END_BYTE;
				phase_d        = FC_HUNT;
			end else if (rem_dec == 32'd0) begin
				lpos_d = '0;
				unique case (phase_q)
					FC_TOTAL: begin
						if (len < MIN_FRAME_LEN || {1'b0, len} > lim) begin
							res.frame_done = 1'b1;
							res.error_kind = ERR_BAD_LEN;
							phase_d        = FC_HUNT;
						end else begin
							total_d = len[15:0];
							phase_d = FC_IDLEN;
							rem_d   = LEN_FIELD_BYTES;
						end
					end
					FC_IDLEN: begin
						if (over_id) begin
							res.frame_done = 1'b1;
							res.error_kind = ERR_OVERRUN;
							phase_d        = FC_HUNT;
						end else if (len != 32'd0) begin
							phase_d = FC_ID;
							rem_d   = len;
						end else begin
							phase_d = FC_NAMELEN;
							rem_d   = LEN_FIELD_BYTES;
						end
					end
					FC_ID: begin
						phase_d = FC_NAMELEN;
						rem_d   = LEN_FIELD_BYTES;
					end
					FC_NAMELEN: begin
						if (over_name) begin
							res.frame_done = 1'b1;
							res.error_kind = ERR_OVERRUN;
							phase_d        = FC_HUNT;
						end else if (len != 32'd0) begin
							phase_d = FC_NAME;
							rem_d   = len;
						end else begin
							phase_d = FC_ERR;
							rem_d   = LEN_FIELD_BYTES;
						end
					end
					FC_NAME: begin
						phase_d = FC_ERR;
						rem_d   = LEN_FIELD_BYTES;
					end
					FC_ERR: begin
						phase_d = FC_INFOLEN;
						rem_d   = LEN_FIELD_BYTES;
					end
					FC_INFOLEN: begin
						if (over_info) begin
							res.frame_done = 1'b1;
							res.error_kind = ERR_OVERRUN;
							phase_d        = FC_HUNT;
						end else if (len != 32'd0) begin
							phase_d = FC_INFO;
							rem_d   = len;
						end else if (pay != 32'd0) begin
							phase_d = FC_PAYLOAD;
							rem_d   = pay;
						end else begin
							phase_d = FC_CHECKSUM;
							rem_d   = LEN_FIELD_BYTES;
						end
					end
					FC_INFO: begin
						if (pay != 32'd0) begin
							phase_d = FC_PAYLOAD;
							rem_d   = pay;
						end else begin
							phase_d = FC_CHECKSUM;
							rem_d   = LEN_FIELD_BYTES;
						end
					end
					FC_PAYLOAD: begin
						phase_d = FC_CHECKSUM;
						rem_d   = LEN_FIELD_BYTES;
					end
					FC_CHECKSUM: begin
						phase_d = FC_END;
						rem_d   = 32'd1;
					end
					default: begin
						phase_d = FC_HUNT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= FC_HUNT;
			fpos_q  <= '0;
			lpos_q  <= '0;
			shift_q <= 32'd0;
			total_q <= 16'd0;
			rem_q   <= 32'd0;
		end else if (en) begin
			phase_q <= phase_d;
			fpos_q  <= fpos_d;
			lpos_q  <= lpos_d;
			shift_q <= shift_d;
			total_q <= total_d;
			rem_q   <= rem_d;
		end
	end

endmodule : rfd_parser
`default_nettype wire

// ===== hw/rtl/rpc_frame_deframer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_frame_deframer_core: streaming deframer for delimited RPC frames
// Hunts for the start byte, walks the length prefixed fields of each frame
// and returns every byte tagged with its field and offset.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Transaction
//  s_axis    in         tdata[7:0] rx_byte                       tvalid & tready
//  m_axis    out        tdata byte/offset/ok/error, tuser field,  tvalid & tready
//                       tlast frame done
//  cfg       in         cfg_addr register index, cfg_data value  cfg_valid & cfg_ready
//
// One byte is accepted per cycle when nothing stalls; each byte passes through
// the input register and the result register before it leaves.
// The rate is set by the parser state, which is updated once per byte.
// Reset clears the parse state to hunting and the registers to their
// defaults; no clearing pass is needed. When m_axis stalls, the result
// register holds and the input register still takes one more byte.
// Configuration writes are taken at once, in any cycle.
//
module rpc_frame_deframer_core
	import rfd_pkg::*;
#(
	parameter int POSITION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [7:0] data_byte, [23:8] field_offset,
	                                         // [24] frame_ok, [26:25] error_kind, rest 0
	output logic [3:0]       m_axis_tuser,   // [3:0] field_code
	output logic             m_axis_tlast,   // frame_done

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_data
);

	rfd_cfg_t    cfg;
	rfd_result_t res;

	// Input register (stage 1) and result register (stage 2).
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	rfd_result_t res_s2;
	logic        advance;

	rfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The parser commits its state only when the byte in stage 1 moves on,
	// so each byte updates the frame state exactly once.
	rfd_parser #(
		.POSITION_BITS (POSITION_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1 && advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Stage 2 may load when it is empty or its result is being taken.
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, res_s2.error_kind, res_s2.frame_ok,
	                        res_s2.field_offset, res_s2.data_byte};
	assign m_axis_tuser  = res_s2.field_code;
	assign m_axis_tlast  = res_s2.frame_done;

	// A good frame is always a finished one.
	a_ok_implies_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tlast)
		else $error("frame_ok without frame_done");

	// A finished frame reports an error exactly when it is not good.
	a_err_matches_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[24] == (m_axis_tdata[26:25] == 2'd0)))
		else $error("error_kind disagrees with frame_ok");

	// Bytes seen while hunting carry no offset and end no frame.
	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == FC_HUNT |->
		m_axis_tdata[23:8] == 16'd0 && !m_axis_tlast)
		else $error("hunting byte with offset or frame end");

	// A byte waiting in stage 1 is not lost while the output stalls.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stage 1 byte dropped during stall");

endmodule : rpc_frame_deframer_core
`default_nettype wire

// ===== tb/sv/tb_rpc_frame_deframer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rpc_frame_deframer_core: self-checking bench for the RPC frame deframer
// Feeds byte streams of well formed and damaged frames under several register
// settings, predicts the tag of every byte and compares each output
// transaction against the oldest predicted tag.
// ----------------------------------------------------------------------------
module tb_rpc_frame_deframer_core;
	import rfd_pkg::*;

	// Predicts the tag of every accepted byte and holds the tags still due.
	// Its parser walks the frame exactly as the block must: one step per
	// accepted byte, with its own copy of the registers.
	class frame_tag_scoreboard;
		logic [7:0]  start_byte;
		logic [7:0]  end_byte;
		logic [15:0] max_len;

		field_code_t parse_state;
		logic [15:0] frame_pos;
		logic [15:0] field_pos;
		logic [31:0] len_shift;
		logic [15:0] total_len;
		logic [31:0] field_rem;

		rfd_result_t tags_due[$];
		int          mismatches;

		function new();
			start_byte  = START_BYTE_RST;
			end_byte    = END_BYTE_RST;
			max_len     = MAX_FRAME_LEN_RST;
			parse_state = FC_HUNT;
			frame_pos   = '0;
			field_pos   = '0;
			len_shift   = '0;
			total_len   = '0;
			field_rem   = '0;
			mismatches  = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [15:0] val);
			case (idx)
				REG_START_BYTE:    start_byte = val[7:0];
				REG_END_BYTE:      end_byte = val[7:0];
				REG_MAX_FRAME_LEN: max_len = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return tags_due.size();
		endfunction

		function void open_field(field_code_t code, logic [31:0] size);
			parse_state = code;
			field_pos   = '0;
			field_rem   = size;
		endfunction

		// The payload takes whatever is left before checksum and end byte.
		function void open_payload();
			logic [63:0] left;
			left = {48'b0, total_len} - {48'b0, frame_pos};
			if (left > {30'b0, TAIL_AFTER_INFO})
				open_field(FC_PAYLOAD, 32'(left - {30'b0, TAIL_AFTER_INFO}));
			else
				open_field(FC_CHECKSUM, LEN_FIELD_BYTES);
		endfunction

		// A declared field plus the fixed fields behind it must fit within
		// the total frame length.
		function bit overruns(logic [31:0] len, logic [33:0] tail);
			return ({48'b0, frame_pos} + {32'b0, len} + {30'b0, tail}) >
				{48'b0, total_len};
		endfunction

		function void note_byte(logic [7:0] b);
			rfd_result_t tag;
			field_code_t code;
			logic [31:0] len;
			tag            = '0;
			tag.data_byte  = b;
			tag.field_code = FC_HUNT;
			tag.error_kind = ERR_NONE;
			if (parse_state < FC_TOTAL || parse_state > FC_END) begin
				parse_state = FC_HUNT;
				if (b == start_byte) begin
					tag.field_code = FC_START;
					frame_pos      = 16'd1;
					len_shift      = '0;
					total_len      = '0;
					open_field(FC_TOTAL, LEN_FIELD_BYTES);
				end
			end else begin
				code             = parse_state;
				tag.field_code   = code;
				tag.field_offset = field_pos;
				frame_pos        = frame_pos + 16'd1;
				field_pos        = field_pos + 16'd1;
				if (field_rem != 0)
					field_rem = field_rem - 32'd1;
				len_shift = {len_shift[23:0], b};
				len       = len_shift;
				if (code == FC_END) begin
					tag.frame_done = 1'b1;
					tag.frame_ok   = (b == end_byte);
					tag.error_kind = (b == end_byte) ? ERR_NONE : ERR_END_BYTE;
					parse_state    = FC_HUNT;
				end else if (field_rem == 0) begin
					case (code)
						FC_TOTAL: begin
							if (len < MIN_FRAME_LEN || len > {16'b0, max_len}) begin
								tag.frame_done = 1'b1;
								tag.error_kind = ERR_BAD_LEN;
								parse_state    = FC_HUNT;
							end else begin
								total_len = len[15:0];
								open_field(FC_IDLEN, LEN_FIELD_BYTES);
							end
						end
						FC_IDLEN: begin
							if (overruns(len, TAIL_AFTER_ID)) begin
								tag.frame_done = 1'b1;
								tag.error_kind = ERR_OVERRUN;
								parse_state    = FC_HUNT;
							end else if (len != 0) begin
								open_field(FC_ID, len);
							end else begin
								open_field(FC_NAMELEN, LEN_FIELD_BYTES);
							end
						end
						FC_ID: open_field(FC_NAMELEN, LEN_FIELD_BYTES);
						FC_NAMELEN: begin
							if (overruns(len, TAIL_AFTER_NAME)) begin
								tag.frame_done = 1'b1;
								tag.error_kind = ERR_OVERRUN;
								parse_state    = FC_HUNT;
							end else if (len != 0) begin
								open_field(FC_NAME, len);
							end else begin
								open_field(FC_ERR, LEN_FIELD_BYTES);
							end
						end
						FC_NAME: open_field(FC_ERR, LEN_FIELD_BYTES);
						FC_ERR: open_field(FC_INFOLEN, LEN_FIELD_BYTES);
						FC_INFOLEN: begin
							if (overruns(len, TAIL_AFTER_INFO)) begin
								tag.frame_done = 1'b1;
								tag.error_kind = ERR_OVERRUN;
								parse_state    = FC_HUNT;
							end else if (len != 0) begin
								open_field(FC_INFO, len);
							end else begin
								open_payload();
							end
						end
						FC_INFO: open_payload();
						FC_PAYLOAD: open_field(FC_CHECKSUM, LEN_FIELD_BYTES);
						FC_CHECKSUM: open_field(FC_END, 32'd1);
						default: parse_state = FC_HUNT;
					endcase
				end
			end
			tags_due.insert(tags_due.size(), tag);
		endfunction

		function string tag_text(rfd_result_t t);
			return $sformatf("byte %02h code %0d offset %0d done %b ok %b err %0d",
				t.data_byte, t.field_code, t.field_offset, t.frame_done,
				t.frame_ok, t.error_kind);
		endfunction

		function void check_tag(rfd_result_t got);
			rfd_result_t want;
			if (tags_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transaction: %s", tag_text(got));
				return;
			end
			want = tags_due.pop_front();
			if (got.data_byte !== want.data_byte || got.field_code !== want.field_code ||
					got.field_offset !== want.field_offset ||
					got.frame_done !== want.frame_done || got.frame_ok !== want.frame_ok ||
					got.error_kind !== want.error_kind) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("tag mismatch at %0t", $realtime);
					$display("  expected %s", tag_text(want));
					$display("  actual   %s", tag_text(got));
				end
			end
		endfunction
	endclass

	// Ways in which a generated frame is damaged.
	typedef enum int {
		FAULT_NONE,
		FAULT_END_BYTE,
		FAULT_LEN_LOW,
		FAULT_LEN_HIGH,
		FAULT_ID_OVER,
		FAULT_NAME_OVER,
		FAULT_INFO_OVER,
		FAULT_TRUNCATE,
		FAULT_AT_MAX
	} frame_fault_t;

	localparam int ITEMS_PER_PHASE = 165;
	localparam int NUM_PHASES      = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr = REG_START_BYTE;
	logic [15:0] cfg_data = 16'h0000;

	// Set for a long stretch once, so that the block backs up into its input.
	logic        hold_off = 1'b0;

	frame_tag_scoreboard sb;
	logic [7:0]  stream[$];
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;

	rpc_frame_deframer_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// Append one byte at the tail of the queued stream.
	task automatic queue_byte(input logic [7:0] b);
		stream.insert(stream.size(), b);
	endtask

	// Append a 32-bit length field, most significant byte first.
	task automatic push_word(input logic [31:0] w);
		queue_byte(w[31:24]);
		queue_byte(w[23:16]);
		queue_byte(w[15:8]);
		queue_byte(w[7:0]);
	endtask

	task automatic push_random(input int unsigned n);
		repeat (n) queue_byte(8'($urandom));
	endtask

	// Draw the size of one variable field from what is left of the room
	// under the current length limit. A third of the fields are empty.
	task automatic take_size(inout int unsigned room, output int unsigned n);
		if (room == 0 || $urandom_range(0, 2) == 0)
			n = 0;
		else
			n = $urandom_range(1, (room < 8) ? room : 8);
		room = room - n;
	endtask

	// Queue one frame with the given field sizes, damaged as the fault says.
	// Length faults stop after the total length field, since the block drops
	// back to hunting there; other faults keep the real layout behind them so
	// the remaining bytes reach the block as stray data.
	task automatic build_frame(input frame_fault_t fault, input int unsigned id_n,
			input int unsigned name_n, input int unsigned info_n,
			input int unsigned pay_n);
		int unsigned total;
		logic [31:0] total_f;
		logic [31:0] id_f;
		logic [31:0] name_f;
		logic [31:0] info_f;
		logic [7:0]  last_byte;
		total   = MIN_FRAME_LEN + id_n + name_n + info_n + pay_n;
		total_f = total;
		id_f    = id_n;
		name_f  = name_n;
		info_f  = info_n;
		last_byte = sb.end_byte;
		case (fault)
			FAULT_END_BYTE: last_byte = sb.end_byte ^ 8'($urandom_range(1, 255));
			FAULT_LEN_LOW: total_f = $urandom_range(0, 1) ? 32'd25 : $urandom_range(0, 25);
			FAULT_LEN_HIGH: begin
				if (sb.max_len == 16'hFFFF)
					total_f = $urandom_range(0, 1) ? 32'h0001_0000 : ($urandom | 32'h0001_0000);
				else
					total_f = {16'b0, sb.max_len} + 32'd1 + $urandom_range(0, 2);
			end
			// One to three past the largest declared size that still fits, or far past.
			FAULT_ID_OVER: id_f = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
				total - 25 + $urandom_range(0, 2);
			FAULT_NAME_OVER: name_f = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
				total - 25 - id_n + $urandom_range(0, 2);
			FAULT_INFO_OVER: info_f = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
				total - 25 - id_n - name_n + $urandom_range(0, 2);
			default: ;
		endcase
		queue_byte(sb.start_byte);
		push_word(total_f);
		if (fault == FAULT_LEN_LOW || fault == FAULT_LEN_HIGH)
			return;
		push_word(id_f);
		push_random(id_n);
		push_word(name_f);
		push_random(name_n);
		push_random(4);
		push_word(info_f);
		push_random(info_n);
		push_random(pay_n);
		push_random(4);
		queue_byte(last_byte);
		// A cut-off frame lets the next frame's bytes land in its fields.
		if (fault == FAULT_TRUNCATE)
			repeat ($urandom_range(1, total - 1)) void'(stream.pop_back());
	endtask

	// Queue random frames, most of them well formed, with a little line noise
	// in front of each, until the phase has enough bytes.
	task automatic build_random_frames();
		int unsigned room;
		int unsigned id_n;
		int unsigned name_n;
		int unsigned info_n;
		int unsigned pay_n;
		int unsigned pick;
		frame_fault_t fault;
		logic [7:0] noise;
		while (stream.size() < ITEMS_PER_PHASE) begin
			repeat ($urandom_range(0, 2)) begin
				noise = 8'($urandom);
				if (noise == sb.start_byte && $urandom_range(0, 3) != 0)
					noise = ~noise;
				queue_byte(noise);
			end
			room = sb.max_len - 26;
			if (room > 60)
				room = 60;
			take_size(room, id_n);
			take_size(room, name_n);
			take_size(room, info_n);
			take_size(room, pay_n);
			pick = $urandom_range(0, 19);
			case (pick)
				12: fault = FAULT_END_BYTE;
				13: fault = FAULT_LEN_LOW;
				14: fault = FAULT_LEN_HIGH;
				15: fault = FAULT_ID_OVER;
				16: fault = FAULT_NAME_OVER;
				17: fault = FAULT_INFO_OVER;
				18: fault = FAULT_TRUNCATE;
				19: fault = FAULT_AT_MAX;
				default: fault = FAULT_NONE;
			endcase
			// A frame exactly as long as the limit allows, where that is short.
			if (fault == FAULT_AT_MAX) begin
				fault = FAULT_NONE;
				if (sb.max_len <= 400)
					pay_n = sb.max_len - 26 - id_n - name_n - info_n;
			end else if (fault == FAULT_NONE && sb.max_len >= 400 &&
					$urandom_range(0, 24) == 0) begin
				// An occasional long payload pushes the offset past one byte.
				pay_n = $urandom_range(256, 300);
			end
			build_frame(fault, id_n, name_n, info_n, pay_n);
		end
	endtask

	// Offer the queued bytes in bursts of random length. Between bursts the
	// sender may pause; each byte is handed to the scoreboard at the edge
	// where its transaction completes.
	task automatic send_stream(input bit gaps_on);
		logic [7:0] b;
		while (stream.size() != 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 32);
				if (gaps_on && $urandom_range(0, 3) != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			burst_left--;
			b = stream.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= b;
			do @(posedge clk); while (!s_axis_tready);
			sb.note_byte(b);
			items_sent++;
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// Let every predicted tag come back, then let the pipeline settle.
	task automatic wait_drained(input int unsigned settle);
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write all three registers back to back. The upper byte of the data for
	// the byte-wide registers is random, since only the low byte counts.
	task automatic program_regs(input logic [7:0] sbyte, input logic [7:0] ebyte,
			input logic [15:0] maxl);
		cfg_index_t  idx[3];
		logic [15:0] vals[3];
		idx[0]  = REG_START_BYTE;
		idx[1]  = REG_END_BYTE;
		idx[2]  = REG_MAX_FRAME_LEN;
		vals[0] = {8'($urandom), sbyte};
		vals[1] = {8'($urandom), ebyte};
		vals[2] = maxl;
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Main sequence: reset, a short directed part under the reset values of
	// the registers, then one random phase per register setting.
	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: both extreme byte values while hunting, a frame in
		// which every variable field holds one byte, and a length below the minimum.
		queue_byte(8'h00);
		queue_byte(8'hFF);
		build_frame(FAULT_NONE, 1, 1, 1, 1);
		build_frame(FAULT_LEN_LOW, 0, 0, 0, 0);
		send_stream(1'b0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				wait_drained(4);
				case (ph)
					1: program_regs(8'h00, 8'hFF, 16'd26);
					2: program_regs(8'hFF, 8'h00, 16'hFFFF);
					// Start and end share one value: the end byte of a frame
					// must not open the next one.
					3: program_regs(8'h7E, 8'h7E, 16'($urandom_range(26, 120)));
					4: program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(26, 400)));
					default: program_regs(8'($urandom), 8'($urandom),
						16'($urandom_range(26, 65535)));
				endcase
			end
			build_random_frames();
			send_stream(ph != 2);
		end

		wait_drained(16);
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Receiver: checks every output transaction and stalls on a rotating
	// pattern that is redrawn after a randomly drawn span; a quarter of the
	// patterns are all ones, so some stretches run without stalls.
	initial begin
		rfd_result_t got;
		logic [15:0] pat;
		int unsigned span;
		pat  = '1;
		span = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.data_byte    = m_axis_tdata[7:0];
				got.field_offset = m_axis_tdata[23:8];
				got.frame_ok     = m_axis_tdata[24];
				got.error_kind   = error_kind_t'(m_axis_tdata[26:25]);
				got.field_code   = field_code_t'(m_axis_tuser);
				got.frame_done   = m_axis_tlast;
				sb.check_tag(got);
			end
			if (span == 0) begin
				span = $urandom_range(20, 120);
				pat  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
			end
			span--;
			pat = {pat[0], pat[15:1]};
			m_axis_tready <= pat[0] && !hold_off;
		end
	end

	// Long hold-off once 250 bytes have been sent, while the sender keeps
	// offering bytes, so that the block fills and drops its input ready.
	initial begin
		wait (items_sent >= 250);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
